@@ rtl/lpg_pkg.sv @@
package lpg_pkg;

  typedef struct packed {
    logic load;
    logic step;
  } axis_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } lpg_state_t;

endpackage

@@ rtl/lpg_axis.sv @@
module lpg_axis
  import lpg_pkg::*;
#(
  parameter int COORD_BITS = 6
) (
  input  logic                  clk,
  input  axis_ctrl_t            ctrl,
  input  logic [COORD_BITS-1:0] start_c,
  input  logic [COORD_BITS-1:0] end_c,
  input  logic [COORD_BITS-1:0] span,
  output logic [COORD_BITS-1:0] point
);

  localparam int RW = COORD_BITS + 3;

  // The coordinate is the quotient of a running numerator over twice the span;
  // the remainder stays in [0, 2N) and the quotient moves by at most one a step.
  logic signed [COORD_BITS:0] d_r, d_nxt;
  logic signed [RW-1:0]       rem_r, rem_nxt;
  logic [COORD_BITS-1:0]      q_r, q_nxt;
  logic signed [RW-1:0]       twice_n;
  logic signed [RW-1:0]       sum;

  assign twice_n = $signed({2'b00, span, 1'b0});
  assign sum     = rem_r + $signed({{(RW-COORD_BITS-2){d_r[COORD_BITS]}}, d_r, 1'b0});

  always_comb begin
    d_nxt   = d_r;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    if (ctrl.load) begin
      d_nxt   = $signed({1'b0, end_c}) - $signed({1'b0, start_c});
      rem_nxt = $signed({3'b000, span});
      q_nxt   = start_c;
    end else if (ctrl.step) begin
      if (sum >= twice_n) begin
        rem_nxt = sum - twice_n;
        q_nxt   = q_r + 1'b1;
      end else if (sum < 0) begin
        rem_nxt = sum + twice_n;
        q_nxt   = q_r - 1'b1;
      end else begin
        rem_nxt = sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign point = q_r;

endmodule

@@ rtl/line_point_generator_unit.sv @@
// Latency: the first point is offered in the cycle after the request beat.
// Throughput: a request of span N yields N+1 points; the per-axis stepper produces
// one point a cycle while the output does not stall, and in_tready is low until
// the last point is taken, so a new request waits until the last point is taken.
// Reset: synchronous, active low; it returns the sequencer to idle.
module line_point_generator_unit
  import lpg_pkg::*;
#(
  parameter int COORD_BITS = 6
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // start_x, start_y, end_x, end_y, zero fill
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]    in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // point_x, point_y, zero fill
  output logic [((2*COORD_BITS+7)/8)*8-1:0]    out_tdata,
  output logic                                 out_tlast
);

  localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

  lpg_state_t            state_r, state_nxt;
  logic [COORD_BITS-1:0] span_r, span_nxt;
  logic [COORD_BITS-1:0] k_r, k_nxt;
  logic [COORD_BITS-1:0] start_x, start_y, end_x, end_y;
  logic [COORD_BITS-1:0] adx, ady, span_in;
  logic [COORD_BITS-1:0] point_x, point_y;
  logic                  in_beat, out_beat, is_last;
  axis_ctrl_t            ctrl;

  assign start_x = in_tdata[COORD_BITS-1:0];
  assign start_y = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign end_x   = in_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign end_y   = in_tdata[4*COORD_BITS-1:3*COORD_BITS];

  assign adx     = (end_x > start_x) ? end_x - start_x : start_x - end_x;
  assign ady     = (end_y > start_y) ? end_y - start_y : start_y - end_y;
  assign span_in = (adx > ady) ? adx : ady;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_EMIT);
  assign in_beat    = in_tvalid && in_tready;
  assign out_beat   = out_tvalid && out_tready;
  assign is_last    = (k_r == span_r);

  assign ctrl.load = in_beat;
  assign ctrl.step = out_beat && !is_last;

  always_comb begin
    state_nxt = state_r;
    span_nxt  = span_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          state_nxt = ST_EMIT;
          span_nxt  = span_in;
          k_nxt     = '0;
        end
      end
      ST_EMIT: begin
        if (out_beat) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    span_r <= span_nxt;
    k_r    <= k_nxt;
  end

  lpg_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .clk     (clk),
    .ctrl    (ctrl),
    .start_c (start_x),
    .end_c   (end_x),
    .span    (in_beat ? span_in : span_r),
    .point   (point_x)
  );

  lpg_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .clk     (clk),
    .ctrl    (ctrl),
    .start_c (start_y),
    .end_c   (end_y),
    .span    (in_beat ? span_in : span_r),
    .point   (point_y)
  );

  assign out_tdata = {{(OUT_W-2*COORD_BITS){1'b0}}, point_y, point_x};
  assign out_tlast = is_last;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int CB = 6;
  localparam int NUM_DIRECTED = 20;
  localparam int NUM_RANDOM = 280;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          last;
  } line_point_t;

  typedef struct {
    int sx;
    int sy;
    int ex;
    int ey;
    bit fixed;
    int fx;
    int fy;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;

  line_point_t expected_points[$];
  plan_row_t   directed_plan[NUM_DIRECTED];
  bit          idle_on;
  bit          hold_request;
  int          failures = 0;
  int          requests_sent = 0;
  int          points_seen = 0;
  int          widest_span = 0;

  line_point_generator_unit #(
    .COORD_BITS(CB)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #6 clk = ~clk;

  // Rounds half away from zero; the interpolated value is never negative here.
  function automatic int round_axis(int s, int e, int k, int n);
    int num;
    num = s * n + k * (e - s);
    return (2 * num + n) / (2 * n);
  endfunction

  function automatic void predict_line(int sx, int sy, int ex, int ey);
    int dx, dy, n, k;
    line_point_t p;
    dx = ex > sx ? ex - sx : sx - ex;
    dy = ey > sy ? ey - sy : sy - ey;
    n = dx > dy ? dx : dy;
    if (n > widest_span) widest_span = n;
    if (n == 0) begin
      p.x = CB'(sx);
      p.y = CB'(sy);
      p.last = 1'b1;
      expected_points.push_back(p);
    end else begin
      for (k = 0; k <= n; k++) begin
        p.x = CB'(round_axis(sx, ex, k, n));
        p.y = CB'(round_axis(sy, ey, k, n));
        p.last = (k == n);
        expected_points.push_back(p);
      end
    end
  endfunction

  function automatic int near(int c);
    int v;
    v = c + $urandom_range(0, 8) - 4;
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return v;
  endfunction

  task automatic send_line(int sx, int sy, int ex, int ey, bit fixed, int fx, int fy);
    line_point_t p;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {CB'(ey), CB'(ex), CB'(sy), CB'(sx)};
    do @(posedge clk); while (!in_tready);
    if (fixed) begin
      p.x = CB'(fx);
      p.y = CB'(fy);
      p.last = 1'b1;
      expected_points.push_back(p);
    end else begin
      predict_line(sx, sy, ex, ey);
    end
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic await_drain();
    int waited;
    waited = 0;
    while (expected_points.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  always @(posedge clk) begin : point_monitor
    line_point_t want;
    if (rst_n && out_tvalid && out_tready) begin
      points_seen++;
      if (expected_points.size() == 0) begin
        $error("unexpected point beat: x %0d, y %0d, last %0b",
               out_tdata[CB-1:0], out_tdata[2*CB-1:CB], out_tlast);
        failures++;
      end else begin
        want = expected_points.pop_front();
        if (out_tdata[CB-1:0] !== want.x) begin
          $error("point_x: expected %0d, actual %0d", want.x, out_tdata[CB-1:0]);
          failures++;
        end
        if (out_tdata[2*CB-1:CB] !== want.y) begin
          $error("point_y: expected %0d, actual %0d", want.y, out_tdata[2*CB-1:CB]);
          failures++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_tlast);
          failures++;
        end
      end
    end
  end

  initial begin : receiver
    int gap;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        for (gap = 0; gap < LONG_HOLD; gap++) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int i, sx, sy, ex, ey;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    idle_on = 1'b0;
    hold_request = 1'b0;
    // Zero-span rows carry their single point; every other row goes to the predictor.
    directed_plan = '{
      '{ 0,  0,  0,  0, 1,  0,  0},
      '{63, 63, 63, 63, 1, 63, 63},
      '{42, 21, 42, 21, 1, 42, 21},
      '{21, 42, 21, 42, 1, 21, 42},
      '{ 0,  0, 63, 63, 0,  0,  0},
      '{63, 63,  0,  0, 0,  0,  0},
      '{ 0, 63, 63,  0, 0,  0,  0},
      '{63,  0,  0, 63, 0,  0,  0},
      '{ 0,  5, 63,  5, 0,  0,  0},
      '{ 7,  0,  7, 63, 0,  0,  0},
      '{ 0,  0, 63,  1, 0,  0,  0},
      '{ 0,  0,  2,  1, 0,  0,  0},
      '{ 2,  1,  0,  0, 0,  0,  0},
      '{ 0,  1,  4,  0, 0,  0,  0},
      '{10, 10, 11, 11, 0,  0,  0},
      '{ 5,  5,  4,  6, 0,  0,  0},
      '{42, 21, 21, 42, 0,  0,  0},
      '{21, 42, 42, 21, 0,  0,  0},
      '{ 0,  0, 62, 31, 0,  0,  0},
      '{33, 12, 30, 13, 0,  0,  0}
    };
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    idle_on = 1'b1;

    for (i = 0; i < NUM_DIRECTED; i++) begin
      send_line(directed_plan[i].sx, directed_plan[i].sy, directed_plan[i].ex,
                directed_plan[i].ey, directed_plan[i].fixed, directed_plan[i].fx,
                directed_plan[i].fy);
    end

    for (i = 0; i < NUM_RANDOM; i++) begin
      idle_on = !(i >= 60 && i < 100) && (i < NUM_RANDOM - 40);
      if (i == 120) hold_request = 1'b1;
      if (i == 200) begin
        in_tvalid <= 1'b0;
        await_drain();
        @(negedge clk);
      end
      sx = $urandom_range(0, 63);
      sy = $urandom_range(0, 63);
      ex = $urandom_range(0, 63);
      ey = $urandom_range(0, 63);
      case ($urandom_range(0, 9))
        0: begin
          ex = sx;
          ey = sy;
        end
        1, 2: begin
          ex = near(sx);
          ey = near(sy);
        end
        3: ey = sy;
        4: ex = sx;
        default: ;
      endcase
      send_line(sx, sy, ex, ey, 1'b0, 0, 0);
    end

    in_tvalid <= 1'b0;
    await_drain();
    repeat (8) @(posedge clk);
    if (expected_points.size() != 0) begin
      $error("%0d expected points never arrived", expected_points.size());
      failures++;
    end
    $display("Ran %0d requests: extremes, zero spans, rounding halves, random lines; %0d points.",
             requests_sent, points_seen);
    $display("Widest span %0d; output held off %0d cycles once and input paused to drain once.",
             widest_span, LONG_HOLD);
    if (failures == 0) begin
      $display("line_point_generator_unit verification clean");
    end else begin
      $display("line_point_generator_unit verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(30_000_000);
    $display("line_point_generator_unit verification failed");
    $finish;
  end

endmodule
